// ----- hw/rtl/tps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tps_pkg
// Shared constants and codes for the tilt plate setpoint generator.
// ----------------------------------------------------------------------------
package tps_pkg;

    // field widths fixed by the register map
    localparam int CFG_DATA_BITS  = 20;
    localparam int CFG_INDEX_BITS = 3;
    localparam int TAN_BITS       = 18;
    localparam int TILT_BITS      = 16;
    localparam int UM_BITS        = 20;

    // fixed numeric constants
    localparam int MIN_SETPOINT_UM = 4000;
    localparam int GATE_WINDOW2_UM = 20000;
    localparam int US_PER_S        = 1000000;

    // homing command codes
    localparam logic [1:0] CMD_KEEP    = 2'd0;
    localparam logic [1:0] CMD_REQUEST = 2'd1;
    localparam logic [1:0] CMD_CANCEL  = 2'd2;

    // homing line drive codes
    localparam logic [1:0] HD_NONE = 2'd0;
    localparam logic [1:0] HD_LOW  = 2'd1;
    localparam logic [1:0] HD_HIGH = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT_FRAC = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ANGLE       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_TILT    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_EXT     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_SEP    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_HEIGHT  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT_RATE = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TILT_RATE   = 3'd7;

endpackage
`default_nettype wire

// ----- hw/rtl/tps_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tps_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module tps_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1025
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/tilt_plate_setpoint_generator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a home word passes the multiply, divide, slew, table read, interpolation
//   and final states before S_DONE; a word with the switch open goes straight to S_DONE.
// Flow: one word at a time; S_DONE waits for a free output register, then returns to idle;
//   the serial shift-add multiplier (20 steps, used five times) and the bit-serial
//   divide by 10^6 (21 steps, used twice) make up most of a home word's work.
// Reset: synchronous, active low; afterwards the tangent table is filled, one entry a
//   cycle, during which no word is accepted.
// ----------------------------------------------------------------------------
// tilt_plate_setpoint_generator
// Homing control, slew-limited height and tilt, and front/rear setpoints.
// ----------------------------------------------------------------------------
module tilt_plate_setpoint_generator #(
    parameter int TAN_TABLE_ENTRIES = 1025,
    parameter int POSITION_BITS     = 20
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [tps_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [tps_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // input words
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic                                i_home_switch,
    input  wire logic [POSITION_BITS-1:0]            i_front_position_um,
    input  wire logic [POSITION_BITS-1:0]            i_rear_position_um,
    input  wire logic [19:0]                         i_step_us,
    input  wire logic [1:0]                          i_homing_cmd,
    // result words
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [POSITION_BITS-1:0]            o_front_setpoint_um,
    output logic      [POSITION_BITS-1:0]            o_rear_setpoint_um,
    output logic                                     o_setpoints_valid,
    output logic      [1:0]                          o_homing_drive
);

    import tps_pkg::*;

    localparam int AW  = $clog2(TAN_TABLE_ENTRIES);
    localparam int PSW = 14 + AW;
    localparam int GW  = ((POSITION_BITS + 1 > 21) ? POSITION_BITS + 1 : 21) + 1;

    typedef logic [TAN_BITS-1:0] t_tan_rom [TAN_TABLE_ENTRIES];

    // restoring unsigned divide for the table build
    function automatic longint unsigned f_udiv(longint unsigned a, longint unsigned b);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], a[i]};
            if (r >= b) begin
                r    = r - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // alternating taylor series in Q30: start 1 gives sin, start 0 gives cos
    function automatic longint f_taylor(longint unsigned x, longint unsigned first,
                                        longint unsigned start);
        longint unsigned x2;
        longint unsigned term;
        longint unsigned n;
        longint          sum;
        x2   = (x * x) >> 30;
        term = first;
        sum  = longint'(first);
        n    = start;
        for (int i = 0; i < 24; i++) begin
            if (term != 0) begin
                term = f_udiv((term * x2) >> 30, (n + 1) * (n + 2));
                n    = n + 2;
                if (i[0]) sum = sum + longint'(term);
                else      sum = sum - longint'(term);
            end
        end
        return sum;
    endfunction

    // tangent table, Q2.16, evaluated at elaboration
    function automatic t_tan_rom f_tan_rom();
        t_tan_rom        rom;
        longint unsigned x;
        longint          s;
        longint          c;
        longint unsigned q;
        for (int k = 0; k < TAN_TABLE_ENTRIES; k++) begin
            x = f_udiv(longint'(k) << 30, longint'(TAN_TABLE_ENTRIES - 1));
            s = f_taylor(x, x, 1);
            c = f_taylor(x, 64'd1 << 30, 0);
            if (s < 0) s = 0;
            if (c < 1) c = 1;
            q = f_udiv((longint'(s) << 16) + (longint'(c) >> 1), longint'(c));
            rom[k] = q[TAN_BITS-1:0];
        end
        return rom;
    endfunction

    localparam t_tan_rom TAN_ROM = f_tan_rom();

    typedef enum logic [3:0] {
        S_FILL, S_IDLE, S_HT_MUL, S_HL_MUL, S_HL_DIV, S_TL_MUL, S_TL_DIV, S_SLEW,
        S_ADDR, S_RD0, S_RD1, S_RD2, S_INTERP, S_OFF_MUL, S_FINAL, S_DONE
    } t_state;

    t_state r_state;

    // configuration registers
    logic        [15:0] r_cfg_frac;
    logic signed [14:0] r_cfg_angle;
    logic        [13:0] r_cfg_max_tilt;
    logic        [19:0] r_cfg_max_ext;
    logic        [19:0] r_cfg_half_sep;
    logic        [19:0] r_cfg_max_h;
    logic        [19:0] r_cfg_h_rate;
    logic        [15:0] r_cfg_t_rate;

    // tick state
    logic                        r_pending;
    logic        [UM_BITS-1:0]   r_sm_height;
    logic signed [TILT_BITS-1:0] r_sm_tilt;

    // working registers
    logic [19:0]         r_step;
    logic                r_gate_ok;
    logic [19:0]         r_htarget;
    logic [20:0]         r_hlim;
    logic [16:0]         r_tlim;
    logic [39:0]         r_acc;
    logic [19:0]         r_mcand;
    logic [19:0]         r_mplier;
    logic [4:0]          r_cnt;
    logic [19:0]         r_rem;
    logic [20:0]         r_quo;
    logic [AW-1:0]       r_idx;
    logic [13:0]         r_frac;
    logic [TAN_BITS-1:0] r_t0;
    logic                r_up;
    logic                r_neg;
    logic [AW-1:0]       r_fill_addr;

    // result held until the output register is free
    logic [19:0] r_res_front;
    logic [19:0] r_res_rear;
    logic        r_res_sv;
    logic [1:0]  r_res_drive;

    // output register
    logic                     r_out_valid;
    logic [POSITION_BITS-1:0] r_o_front;
    logic [POSITION_BITS-1:0] r_o_rear;
    logic                     r_o_sv;
    logic [1:0]               r_o_drive;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_frac     <= '0;
            r_cfg_angle    <= '0;
            r_cfg_max_tilt <= 14'd8192;
            r_cfg_max_ext  <= 20'd100000;
            r_cfg_half_sep <= 20'd100000;
            r_cfg_max_h    <= 20'd50000;
            r_cfg_h_rate   <= 20'd10000;
            r_cfg_t_rate   <= 16'd1638;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_HEIGHT_FRAC: r_cfg_frac     <= i_cfg_data[15:0];
                CFG_ANGLE:       r_cfg_angle    <= signed'(i_cfg_data[14:0]);
                CFG_MAX_TILT:    r_cfg_max_tilt <= i_cfg_data[13:0];
                CFG_MAX_EXT:     r_cfg_max_ext  <= i_cfg_data;
                CFG_HALF_SEP:    r_cfg_half_sep <= i_cfg_data;
                CFG_MAX_HEIGHT:  r_cfg_max_h    <= i_cfg_data;
                CFG_HEIGHT_RATE: r_cfg_h_rate   <= i_cfg_data;
                CFG_TILT_RATE:   r_cfg_t_rate   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // handshake
    logic in_acc;
    logic out_free;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // homing request after this word's command
    logic pending_new;
    always_comb begin
        case (i_homing_cmd)
            CMD_REQUEST: pending_new = 1'b1;
            CMD_CANCEL:  pending_new = 1'b0;
            default:     pending_new = r_pending;
        endcase
    end

    // mean height gate
    logic signed [GW-1:0] gate_diff;
    logic        [GW-1:0] gate_abs;
    always_comb begin
        gate_diff = signed'(GW'(i_front_position_um)) + signed'(GW'(i_rear_position_um))
                  - signed'(GW'({r_cfg_max_h, 1'b0}));
        gate_abs  = gate_diff[GW-1] ? GW'(-gate_diff) : GW'(gate_diff);
    end

    // serial shift-add step, one multiplier bit a cycle
    logic [20:0] mul_sum;
    logic [39:0] mul_next;
    assign mul_sum  = {1'b0, r_acc[39:20]} + (r_mplier[0] ? {1'b0, r_mcand} : 21'd0);
    assign mul_next = {mul_sum, r_acc[19:1]};

    // serial restoring divide by one million, one quotient bit a cycle
    logic [20:0] div_t;
    logic        div_ge;
    logic [19:0] div_rem;
    logic [20:0] quo_next;
    always_comb begin
        div_t    = {r_rem, r_acc[20]};
        div_ge   = (div_t >= 21'(US_PER_S));
        div_rem  = div_ge ? 20'(div_t - 21'(US_PER_S)) : div_t[19:0];
        quo_next = {r_quo[19:0], div_ge};
    end

    // rate limited height and tilt
    logic signed [15:0] ttarget;
    logic signed [21:0] h_err;
    logic signed [21:0] h_lim;
    logic signed [21:0] h_step;
    logic signed [17:0] t_err;
    logic signed [17:0] t_lim;
    logic signed [17:0] t_step;
    always_comb begin
        ttarget = 16'(r_cfg_angle);
        if (ttarget > signed'({2'b00, r_cfg_max_tilt}))  ttarget = signed'({2'b00, r_cfg_max_tilt});
        if (ttarget < -signed'({2'b00, r_cfg_max_tilt})) ttarget = -signed'({2'b00, r_cfg_max_tilt});
        if (!r_gate_ok) ttarget = '0;
        h_err  = signed'({2'b00, r_htarget}) - signed'({2'b00, r_sm_height});
        h_lim  = signed'({1'b0, r_hlim});
        h_step = h_err;
        if (h_step > h_lim)  h_step = h_lim;
        if (h_step < -h_lim) h_step = -h_lim;
        t_err  = 18'(ttarget) - 18'(r_sm_tilt);
        t_lim  = signed'({1'b0, r_tlim});
        t_step = t_err;
        if (t_step > t_lim)  t_step = t_lim;
        if (t_step < -t_lim) t_step = -t_lim;
    end

    // table position of the tilt magnitude
    logic [13:0]    mag;
    logic [PSW-1:0] tpos;
    assign mag  = r_sm_tilt[TILT_BITS-1] ? 14'(-r_sm_tilt) : r_sm_tilt[13:0];
    assign tpos = PSW'(mag) * PSW'(TAN_TABLE_ENTRIES - 1);

    // tangent table
    logic [AW-1:0]       ram_raddr;
    logic [TAN_BITS-1:0] ram_rdata;
    assign ram_raddr = (r_state == S_RD0) ? r_idx : AW'(r_idx + 1'b1);

    tps_ram #(
        .WIDTH (TAN_BITS),
        .DEPTH (TAN_TABLE_ENTRIES)
    ) u_tan_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_FILL),
        .i_wr_addr (r_fill_addr),
        .i_wr_data (TAN_ROM[r_fill_addr]),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    // interpolated tangent
    logic [17:0]         interp_inc;
    logic [TAN_BITS-1:0] tanq;
    assign interp_inc = 18'((mul_next[31:0] + 32'd8192) >> 14);
    assign tanq       = r_up ? TAN_BITS'(r_t0 + interp_inc) : TAN_BITS'(r_t0 - interp_inc);

    // offset and clamped setpoints
    logic        [22:0] off;
    logic signed [24:0] v_front;
    logic signed [24:0] v_rear;
    logic        [19:0] sp_front;
    logic        [19:0] sp_rear;
    always_comb begin
        off     = 23'((r_acc[37:0] + 38'd32768) >> 16);
        v_front = signed'(25'(r_sm_height)) + (r_neg ? -signed'(25'(off)) : signed'(25'(off)));
        v_rear  = signed'(25'(r_sm_height)) - (r_neg ? -signed'(25'(off)) : signed'(25'(off)));
        if (v_front > signed'(25'(r_cfg_max_ext))) v_front = signed'(25'(r_cfg_max_ext));
        if (v_front < 25'sd4000)                   v_front = 25'(MIN_SETPOINT_UM);
        if (v_rear > signed'(25'(r_cfg_max_ext)))  v_rear  = signed'(25'(r_cfg_max_ext));
        if (v_rear < 25'sd4000)                    v_rear  = 25'(MIN_SETPOINT_UM);
        sp_front = v_front[19:0];
        sp_rear  = v_rear[19:0];
    end

    // output width adaption
    logic [31:0] ext_front;
    logic [31:0] ext_rear;
    assign ext_front = 32'(r_res_front);
    assign ext_rear  = 32'(r_res_rear);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_fill_addr <= '0;
            r_pending   <= 1'b0;
            r_sm_height <= '0;
            r_sm_tilt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_FILL: begin
                    r_fill_addr <= AW'(r_fill_addr + 1'b1);
                    if (r_fill_addr == AW'(TAN_TABLE_ENTRIES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_res_front <= '0;
                        r_res_rear  <= '0;
                        r_res_sv    <= 1'b0;
                        if (!i_home_switch) begin
                            r_pending   <= pending_new;
                            r_res_drive <= pending_new ? HD_HIGH : HD_NONE;
                            r_state     <= S_DONE;
                        end else begin
                            r_pending   <= 1'b0;
                            r_res_drive <= HD_LOW;
                            r_step      <= i_step_us;
                            r_gate_ok   <= (gate_abs < GW'(GATE_WINDOW2_UM));
                            r_acc       <= '0;
                            r_mcand     <= r_cfg_max_h;
                            r_mplier    <= {4'b0, r_cfg_frac};
                            r_cnt       <= 5'd19;
                            r_state     <= S_HT_MUL;
                        end
                    end
                end
                S_HT_MUL: begin
                    if (r_cnt == '0) begin
                        r_htarget <= mul_next[35:16];
                        r_acc     <= '0;
                        r_mcand   <= r_cfg_h_rate;
                        r_mplier  <= r_step;
                        r_cnt     <= 5'd19;
                        r_state   <= S_HL_MUL;
                    end else begin
                        r_acc    <= mul_next;
                        r_mplier <= r_mplier >> 1;
                        r_cnt    <= r_cnt - 1'b1;
                    end
                end
                S_HL_MUL, S_TL_MUL: begin
                    r_acc <= mul_next;
                    if (r_cnt == '0) begin
                        r_rem   <= {1'b0, mul_next[39:21]};
                        r_quo   <= '0;
                        r_cnt   <= 5'd20;
                        r_state <= (r_state == S_HL_MUL) ? S_HL_DIV : S_TL_DIV;
                    end else begin
                        r_mplier <= r_mplier >> 1;
                        r_cnt    <= r_cnt - 1'b1;
                    end
                end
                S_HL_DIV: begin
                    r_rem <= div_rem;
                    r_quo <= quo_next;
                    if (r_cnt == '0) begin
                        r_hlim   <= quo_next;
                        r_acc    <= '0;
                        r_mcand  <= {4'b0, r_cfg_t_rate};
                        r_mplier <= r_step;
                        r_cnt    <= 5'd19;
                        r_state  <= S_TL_MUL;
                    end else begin
                        r_acc <= r_acc << 1;
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_TL_DIV: begin
                    r_rem <= div_rem;
                    r_quo <= quo_next;
                    r_acc <= r_acc << 1;
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_tlim  <= quo_next[16:0];
                        r_state <= S_SLEW;
                    end
                end
                S_SLEW: begin
                    r_sm_height <= 20'(signed'({2'b00, r_sm_height}) + h_step);
                    r_sm_tilt   <= 16'(18'(r_sm_tilt) + t_step);
                    r_state     <= S_ADDR;
                end
                S_ADDR: begin
                    r_idx   <= tpos[PSW-1:14];
                    r_frac  <= tpos[13:0];
                    r_neg   <= r_sm_tilt[TILT_BITS-1];
                    r_state <= S_RD0;
                end
                S_RD0: begin
                    r_state <= S_RD1;
                end
                S_RD1: begin
                    r_t0    <= ram_rdata;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_up     <= (ram_rdata >= r_t0);
                    r_mcand  <= (ram_rdata >= r_t0) ? 20'(ram_rdata - r_t0)
                                                    : 20'(r_t0 - ram_rdata);
                    r_mplier <= {6'b0, r_frac};
                    r_acc    <= '0;
                    r_cnt    <= 5'd19;
                    r_state  <= S_INTERP;
                end
                S_INTERP: begin
                    if (r_cnt == '0) begin
                        r_acc    <= '0;
                        r_mcand  <= r_cfg_half_sep;
                        r_mplier <= 20'(tanq);
                        r_cnt    <= 5'd19;
                        r_state  <= S_OFF_MUL;
                    end else begin
                        r_acc    <= mul_next;
                        r_mplier <= r_mplier >> 1;
                        r_cnt    <= r_cnt - 1'b1;
                    end
                end
                S_OFF_MUL: begin
                    r_acc    <= mul_next;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt - 1'b1;
                    if (r_cnt == '0) r_state <= S_FINAL;
                end
                S_FINAL: begin
                    r_res_front <= sp_front;
                    r_res_rear  <= sp_rear;
                    r_res_sv    <= 1'b1;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_front   <= ext_front[POSITION_BITS-1:0];
                        r_o_rear    <= ext_rear[POSITION_BITS-1:0];
                        r_o_sv      <= r_res_sv;
                        r_o_drive   <= r_res_drive;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_front_setpoint_um = r_o_front;
    assign o_rear_setpoint_um  = r_o_rear;
    assign o_setpoints_valid   = r_o_sv;
    assign o_homing_drive      = r_o_drive;

    // computed setpoints always come with the homing line driven low
    a_sv_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_setpoints_valid |-> o_homing_drive == HD_LOW)
        else $error("setpoints without homing low");

    // a word with the switch open carries zero setpoints
    a_open_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_setpoints_valid |->
            o_front_setpoint_um == '0 && o_rear_setpoint_um == '0)
        else $error("nonzero setpoints on an open switch word");

    // smoothed tilt stays inside the table range
    a_tilt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sm_tilt <= 16'sd16383 && r_sm_tilt >= -16'sd16383)
        else $error("smoothed tilt out of range");

endmodule
`default_nettype wire
